@@ rtl/rbf_pkg.sv @@
// shared types, constants and step functions of the radial brush falloff pipeline
`timescale 1ns / 1ps
`default_nettype none
package rbf_pkg;

  localparam int CELL_COORD_BITS_DEF = 12;
  localparam int CFG_W   = 21;
  localparam int CFG_IDX_W = 3;
  localparam int SQ_STAGES  = 16;  // two root bits per stage
  localparam int DIV_STAGES = 8;   // two quotient bits per stage
  localparam logic [15:0] FALLOFF_RESET = 16'd32768;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_BRUSH_RADIUS  = 3'd2,
    CFG_FADE_BEGIN    = 3'd3,
    CFG_ANCHOR_CENTRE = 3'd4
  } cfg_idx_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic in_circ;
    logic kill;   // zero radius or distance at or beyond radius
    logic full;   // distance within the falloff start
  } side_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqst_t;

  typedef struct packed {
    logic [31:0] num;
    logic [16:0] rem;
    logic [15:0] q;
    logic [16:0] dvs;
  } divst_t;

  function automatic sqst_t sqrt_step(input sqst_t x);
    sqst_t y;
    logic [35:0] cand;
    logic [35:0] trial;
    cand  = {x.rem, x.rad[63:62]};
    trial = {2'b00, x.root, 2'b01};
    y.rad = {x.rad[61:0], 2'b00};
    if (cand >= trial) begin
      y.rem  = 34'(cand - trial);
      y.root = {x.root[30:0], 1'b1};
    end else begin
      y.rem  = cand[33:0];
      y.root = {x.root[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic divst_t div_step(input divst_t x);
    divst_t y;
    logic [17:0] cand;
    cand  = {x.rem, x.num[31]};
    y.num = {x.num[30:0], 1'b0};
    y.dvs = x.dvs;
    if (cand >= {1'b0, x.dvs}) begin
      y.rem = 17'(cand - {1'b0, x.dvs});
      y.q   = {x.q[14:0], 1'b1};
    end else begin
      y.rem = cand[16:0];
      y.q   = {x.q[14:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rbf_front.sv @@
// front stages: offsets, squares, squared distance and the exact radius tests
`timescale 1ns / 1ps
`default_nettype none
module rbf_front #(
  parameter int CB = rbf_pkg::CELL_COORD_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                vin,
  input  wire logic [CB-1:0]       cell_x,
  input  wire logic [CB-1:0]       cell_y,
  input  wire logic [20:0]         center_x,
  input  wire logic [20:0]         center_y,
  input  wire logic [15:0]         brush_radius,
  input  wire logic [15:0]         fade_begin,
  input  wire logic                anchor_centre,
  output logic                     vout,
  output logic [63:0]              rad,
  output rbf_pkg::side_t           side
);
  import rbf_pkg::*;

  localparam int MW  = ((CB + 8) > 20 ? (CB + 8) : 20) + 1;
  localparam int DXW = MW + 1;
  localparam int D2W = 2 * MW + 1;

  logic [31:0] r2_q, sr_q;
  logic [63:0] srsq_q;

  logic                  v1, v2, v3, v4;
  logic signed [DXW-1:0] dx, dy;
  logic [MW-1:0]         ax, ay;
  logic [2*MW-1:0]       sqx, sqy;
  logic [D2W-1:0]        d2;

  logic [CB+7:0]  px, py;
  logic [D2W-1:0] r2e;

  // config-derived products, settled long before an item reaches them
  always_ff @(posedge clk) begin
    r2_q   <= 32'(brush_radius) * 32'(brush_radius);
    sr_q   <= 32'(fade_begin) * 32'(brush_radius);
    srsq_q <= 64'(sr_q) * 64'(sr_q);
  end

  assign px  = {cell_x, anchor_centre, 7'b0};
  assign py  = {cell_y, anchor_centre, 7'b0};
  assign r2e = D2W'(r2_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      vout <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= $signed({{(DXW-CB-8){1'b0}}, px}) - $signed({{(DXW-21){center_x[20]}}, center_x});
      dy  <= $signed({{(DXW-CB-8){1'b0}}, py}) - $signed({{(DXW-21){center_y[20]}}, center_y});
      ax  <= dx[DXW-1] ? MW'(-dx) : dx[MW-1:0];
      ay  <= dy[DXW-1] ? MW'(-dy) : dy[MW-1:0];
      sqx <= (2*MW)'(ax) * (2*MW)'(ax);
      sqy <= (2*MW)'(ay) * (2*MW)'(ay);
      d2  <= D2W'(sqx) + D2W'(sqy);
      side.in_circ <= (brush_radius != 16'd0) && (d2 <= r2e);
      side.kill    <= (brush_radius == 16'd0) || (d2 >= r2e);
      side.full    <= ({d2[31:0], 32'b0} <= srsq_q);
      rad          <= {d2[31:0], 32'b0};
    end
  end

endmodule
`default_nettype wire

@@ rtl/rbf_sqrt.sv @@
// pipelined restoring square root, 64-bit radicand, 32-bit root
`timescale 1ns / 1ps
`default_nettype none
module rbf_sqrt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           vin,
  input  wire logic [63:0]    rad,
  input  wire rbf_pkg::side_t side_in,
  output logic                vout,
  output logic [31:0]         root,
  output rbf_pkg::side_t      side_out
);
  import rbf_pkg::*;

  sqst_t seed;
  sqst_t st [1:SQ_STAGES];
  side_t sd [1:SQ_STAGES];
  logic  vl [1:SQ_STAGES];

  assign seed = {rad, 34'b0, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= SQ_STAGES; i++) vl[i] <= 1'b0;
    end else if (en) begin
      vl[1] <= vin;
      for (int i = 1; i < SQ_STAGES; i++) vl[i+1] <= vl[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1] <= sqrt_step(sqrt_step(seed));
      sd[1] <= side_in;
      for (int i = 1; i < SQ_STAGES; i++) begin
        st[i+1] <= sqrt_step(sqrt_step(st[i]));
        sd[i+1] <= sd[i];
      end
    end
  end

  assign vout     = vl[SQ_STAGES];
  assign root     = st[SQ_STAGES].root;
  assign side_out = sd[SQ_STAGES];

endmodule
`default_nettype wire

@@ rtl/rbf_div.sv @@
// pipelined restoring divider, 32-bit dividend, 17-bit divisor, 16-bit quotient
`timescale 1ns / 1ps
`default_nettype none
module rbf_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           vin,
  input  wire logic [31:0]    num,
  input  wire logic [16:0]    dvs,
  input  wire rbf_pkg::side_t side_in,
  output logic                vout,
  output logic [15:0]         quo,
  output rbf_pkg::side_t      side_out
);
  import rbf_pkg::*;

  divst_t seed;
  divst_t st [1:DIV_STAGES];
  side_t  sd [1:DIV_STAGES];
  logic   vl [1:DIV_STAGES];

  // quotient fits 16 bits, so the upper half seeds the remainder
  assign seed = {{num[15:0], 16'b0}, {1'b0, num[31:16]}, 16'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= DIV_STAGES; i++) vl[i] <= 1'b0;
    end else if (en) begin
      vl[1] <= vin;
      for (int i = 1; i < DIV_STAGES; i++) vl[i+1] <= vl[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1] <= div_step(div_step(seed));
      sd[1] <= side_in;
      for (int i = 1; i < DIV_STAGES; i++) begin
        st[i+1] <= div_step(div_step(st[i]));
        sd[i+1] <= sd[i];
      end
    end
  end

  assign vout     = vl[DIV_STAGES];
  assign quo      = st[DIV_STAGES].q;
  assign side_out = sd[DIV_STAGES];

endmodule
`default_nettype wire

@@ rtl/rbf_back.sv @@
// back stages: smoothstep, weight select, output register with skid entry
`timescale 1ns / 1ps
`default_nettype none
module rbf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           vin,
  input  wire logic [15:0]    fade,
  input  wire rbf_pkg::side_t side_in,
  input  wire logic           res_stall,
  output logic                en,
  output logic                res_valid,
  output logic [16:0]         weight,
  output logic                inside_res
);
  import rbf_pkg::*;

  logic        v1, v2, lv;
  logic [31:0] ff;
  logic [17:0] k;
  logic [49:0] prod;
  side_t       sd1, sd2;
  logic [16:0] lw;
  logic        li;

  logic        sv;
  logic [16:0] sw;
  logic        si;

  logic [50:0] rnd;
  logic [18:0] sm;
  logic [16:0] wsel;
  logic        out_free;

  assign rnd = 51'(prod) + 51'(64'd2147483648);
  assign sm  = rnd[50:32];

  always_comb begin
    if (sd2.kill) begin
      wsel = '0;
    end else if (sd2.full) begin
      wsel = ONE_Q16;
    end else if (sm > 19'(ONE_Q16)) begin
      wsel = '0;
    end else begin
      wsel = 17'(19'(ONE_Q16) - sm);
    end
  end

  assign en       = !sv;
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      lv <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      lv <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ff   <= 32'(fade) * 32'(fade);
      k    <= 18'd196608 - 18'({fade, 1'b0});
      sd1  <= side_in;
      prod <= 50'(ff) * 50'(k);
      sd2  <= sd1;
      lw   <= wsel;
      li   <= sd2.in_circ;
    end
  end

  // last stage transfers every enabled cycle, into the output or the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sv        <= 1'b0;
    end else if (en) begin
      if (out_free) begin
        res_valid <= lv;
      end else begin
        sv <= lv;
      end
    end else if (out_free) begin
      res_valid <= 1'b1;
      sv        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_free) begin
        weight     <= lw;
        inside_res <= li;
      end else begin
        sw <= lw;
        si <= li;
      end
    end else if (out_free) begin
      weight     <= sw;
      inside_res <= si;
    end
  end

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst) sv |-> res_valid)
    else $error("skid entry held without a pending result");
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !inside_res |-> weight == 17'd0)
    else $error("nonzero weight outside the brush");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> weight <= ONE_Q16)
    else $error("weight above full strength");
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !sv)
    else $error("result pending right after reset");
`endif

endmodule
`default_nettype wire

@@ rtl/radial_brush_falloff_weight.sv @@
// top level: config registers, pipeline stages and fade numerator stage
// a cell passes the front, sqrt, t divider, fade numerator, fade divider and back stages to the result
// throughput: one cell per cycle while cell_stall is low, set by the fully pipelined sqrt and two dividers
// a stalled result lets the pipe advance until a valid item sits in the skid entry
// reset: synchronous, clears all valid bits and loads the register reset values
// (center 0, radius 0, falloff start 0.5, corner anchor); no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module radial_brush_falloff_weight #(
  parameter int CELL_COORD_BITS = rbf_pkg::CELL_COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbf_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                         cell_valid,
  output logic                              cell_stall,
  input  wire logic [CELL_COORD_BITS-1:0]   cell_x,
  input  wire logic [CELL_COORD_BITS-1:0]   cell_y,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic [16:0]                       weight,
  output logic                              inside_res
);
  import rbf_pkg::*;

  logic [20:0] center_x, center_y;
  logic [15:0] brush_radius, fade_begin;
  logic        anchor_centre;

  logic        en;
  logic        fv, qv, d1v, gv, d2v;
  logic [63:0] rad;
  logic [31:0] root;
  logic [15:0] t16, fade;
  side_t       fs, qs, d1s, gs, d2s;
  logic [31:0] gnum;
  logic [16:0] gdvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      brush_radius  <= '0;
      fade_begin    <= FALLOFF_RESET;
      anchor_centre <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X:      center_x      <= cfg_data;
        CFG_CENTER_Y:      center_y      <= cfg_data;
        CFG_BRUSH_RADIUS:  brush_radius  <= cfg_data[15:0];
        CFG_FADE_BEGIN:    fade_begin    <= cfg_data[15:0];
        CFG_ANCHOR_CENTRE: anchor_centre <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cell_stall = !en;

  rbf_front #(.CB(CELL_COORD_BITS)) u_front (
    .clk, .rst, .en, .vin(cell_valid), .cell_x, .cell_y,
    .center_x, .center_y, .brush_radius, .fade_begin, .anchor_centre,
    .vout(fv), .rad, .side(fs)
  );

  rbf_sqrt u_sqrt (
    .clk, .rst, .en, .vin(fv), .rad, .side_in(fs),
    .vout(qv), .root, .side_out(qs)
  );

  // t = d / r
  rbf_div u_div_t (
    .clk, .rst, .en, .vin(qv), .num(root), .dvs({1'b0, brush_radius}), .side_in(qs),
    .vout(d1v), .quo(t16), .side_out(d1s)
  );

  // fade numerator and divisor; truncated t not above the start gives fade 0
  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else if (en) begin
      gv <= d1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gnum <= (t16 > fade_begin) ? {16'(t16 - fade_begin), 16'b0} : 32'd0;
      gdvs <= ONE_Q16 - {1'b0, fade_begin};
      gs   <= d1s;
    end
  end

  rbf_div u_div_f (
    .clk, .rst, .en, .vin(gv), .num(gnum), .dvs(gdvs), .side_in(gs),
    .vout(d2v), .quo(fade), .side_out(d2s)
  );

  rbf_back u_back (
    .clk, .rst, .vin(d2v), .fade, .side_in(d2s), .res_stall,
    .en, .res_valid, .weight, .inside_res
  );

endmodule
`default_nettype wire

@@ sim/tb_radial_brush_falloff_weight.sv @@
// testbench for the radial brush falloff weight pipeline: scoreboard plus directed and random traffic
`timescale 1ns / 1ps
`default_nettype none
module tb_radial_brush_falloff_weight;
  import rbf_pkg::*;

  typedef struct {
    logic [16:0] weight;
    logic        in_circ;
  } falloff_res_t;

  class falloff_scoreboard;
    logic signed [20:0] ctr_x, ctr_y;
    logic [15:0] radius, fade_start;
    logic        anchor_mid;
    falloff_res_t pending[$];
    int errors;

    function new();
      ctr_x = 0; ctr_y = 0; radius = 0; fade_start = 16'd32768; anchor_mid = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [20:0] val);
      case (idx)
        CFG_CENTER_X:      ctr_x = val;
        CFG_CENTER_Y:      ctr_y = val;
        CFG_BRUSH_RADIUS:  radius = val[15:0];
        CFG_FADE_BEGIN:    fade_start = val[15:0];
        CFG_ANCHOR_CENTRE: anchor_mid = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned acc, b;
      acc = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= acc + b) begin
          n -= acc + b;
          acc = (acc >> 1) + b;
        end else begin
          acc >>= 1;
        end
        b >>= 2;
      end
      return acc;
    endfunction

    function void note_cell(logic [11:0] cx, logic [11:0] cy);
      longint px, py, dx, dy;
      longint unsigned d2, r2, sr, d24, t16, f16, prod, sm, s;
      falloff_res_t e;
      px = (longint'(cx) << 8) + (anchor_mid ? 128 : 0);
      py = (longint'(cy) << 8) + (anchor_mid ? 128 : 0);
      dx = px - longint'(ctr_x);
      dy = py - longint'(ctr_y);
      d2 = dx * dx + dy * dy;
      r2 = longint'(radius) * radius;
      s = fade_start;
      e.in_circ = (radius != 0) && (d2 <= r2);
      if (radius == 0 || d2 >= r2) begin
        e.weight = 0;
      end else begin
        sr = s * radius;
        if ((d2 << 32) <= sr * sr) begin
          e.weight = 17'd65536;
        end else begin
          d24 = root_floor(d2 << 32);
          t16 = d24 / radius;
          f16 = 0;
          if (t16 > s) f16 = ((t16 - s) << 16) / (65536 - s);
          if (f16 > 65535) f16 = 65535;
          prod = (f16 * f16) * (3 * 65536 - 2 * f16);
          sm = (prod + (64'd1 << 31)) >> 32;
          if (sm > 65536) sm = 65536;
          e.weight = 17'(65536 - sm);
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [16:0] w, logic ins);
      falloff_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: weight %0d inside_res %0d", w, ins);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w !== e.weight) begin
        $error("weight expected %0d actual %0d", e.weight, w);
        errors++;
      end
      if (ins !== e.in_circ) begin
        $error("inside_res expected %0d actual %0d", e.in_circ, ins);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic cell_valid = 0, res_stall = 0;
  logic [11:0] cell_x = 0, cell_y = 0;
  wire cell_stall, res_valid, inside_res;
  wire [16:0] weight;
  falloff_scoreboard sb = new();
  bit sink_quiet = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  radial_brush_falloff_weight i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_valid(cell_valid), .cell_stall(cell_stall), .cell_x(cell_x), .cell_y(cell_y),
    .res_valid(res_valid), .res_stall(res_stall), .weight(weight), .inside_res(inside_res)
  );

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(weight, inside_res);
  end

  // sink stall pattern, redrawn per result
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!sink_quiet && res_valid && !res_stall) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          res_stall <= 1;
          repeat (gap) @(posedge clk);
        end
        res_stall <= 0;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [20:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_cell(logic [11:0] cx, logic [11:0] cy, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      cell_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cell_valid <= 1;
    cell_x <= cx;
    cell_y <= cy;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    sb.note_cell(cx, cy);
  endtask

  task automatic drain();
    cell_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // random brush set up, with extremes mixed in
  task automatic new_brush(int phase);
    logic [15:0] r, s;
    logic [20:0] ccx, ccy;
    case (phase % 6)
      0: r = 16'hFFFF;
      1: r = 16'($urandom_range(1, 8));
      default: r = 16'($urandom_range(1, 6000));
    endcase
    case (phase % 5)
      0: s = 0;
      1: s = 16'hFFFF;
      default: s = 16'($urandom);
    endcase
    if (phase % 7 == 0) begin
      ccx = (phase % 2) ? 21'h0FFFFF : 21'h100000;
      ccy = (phase % 2) ? 21'h100000 : 21'h0FFFFF;
    end else begin
      ccx = 21'($urandom_range(0, 4095 * 256));
      ccy = 21'($urandom_range(0, 4095 * 256));
    end
    write_reg(CFG_CENTER_X, ccx);
    write_reg(CFG_CENTER_Y, ccy);
    write_reg(CFG_BRUSH_RADIUS, 21'(r));
    write_reg(CFG_FADE_BEGIN, 21'(s));
    write_reg(CFG_ANCHOR_CENTRE, 21'($urandom_range(0, 1)));
  endtask

  initial begin
    logic signed [20:0] cxs, cys;
    int span;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // zero radius at reset values, grid corners
    send_cell(0, 0, 0);
    send_cell(12'hFFF, 12'hFFF, 0);
    drain();
    // small brush at (10,10)
    write_reg(CFG_CENTER_X, 21'd2560);
    write_reg(CFG_CENTER_Y, 21'd2560);
    write_reg(CFG_BRUSH_RADIUS, 16'd1024);
    write_reg(CFG_FADE_BEGIN, 16'd32768);
    write_reg(CFG_ANCHOR_CENTRE, 1'b0);
    send_cell(10, 10, 0);   // centre
    send_cell(14, 10, 0);   // exactly on the edge
    send_cell(12, 10, 0);   // on the falloff start
    send_cell(13, 10, 0);
    send_cell(12, 12, 0);
    send_cell(0, 4095, 0);
    send_cell(4095, 0, 0);
    drain();
    write_reg(CFG_ANCHOR_CENTRE, 1'b1);
    write_reg(CFG_FADE_BEGIN, 16'hFFFF);
    send_cell(10, 10, 0);
    send_cell(13, 9, 0);
    send_cell(12, 11, 1);
    drain();
    write_reg(CFG_FADE_BEGIN, 16'd0);
    write_reg(CFG_BRUSH_RADIUS, 16'hFFFF);
    send_cell(13, 13, 0);
    send_cell(200, 10, 1);
    send_cell(265, 10, 1);
    send_cell(4095, 4095, 1);
    drain();
    for (int ph = 0; ph < 38; ph++) begin
      new_brush(ph);
      sink_quiet = (ph % 4 == 3);
      cxs = sb.ctr_x;
      cys = sb.ctr_y;
      span = sb.radius / 256 + 2;
      for (int k = 0; k < 50; k++) begin
        int x, y;
        if ($urandom_range(0, 4) == 0) begin
          x = $urandom_range(0, 4095);
          y = $urandom_range(0, 4095);
        end else begin
          x = (cxs >>> 8) + $urandom_range(0, 2 * span) - span;
          y = (cys >>> 8) + $urandom_range(0, 2 * span) - span;
          if (x < 0) x = 0;
          if (x > 4095) x = 4095;
          if (y < 0) y = 0;
          if (y > 4095) y = 4095;
        end
        send_cell(12'(x), 12'(y), ph % 3 == 2);
      end
      drain();
    end
    sink_quiet = 0;
    if (sb.errors == 0) begin
      $display("radial_brush_falloff_weight test passed");
    end else begin
      $display("radial_brush_falloff_weight test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("radial_brush_falloff_weight test failed");
    $finish;
  end
endmodule
`default_nettype wire
